@@ hdl/slr_pkg.sv @@
// shared types and constants for the stereo linear resampler
// no dependencies; used by slr_blend, stereo_linear_resampler_unit and the testbench
package slr_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // serial step counts of the position multiply and the blend unit
  localparam int unsigned MUL_CYC  = 16;
  localparam int unsigned BDIV_CYC = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd48000;

  // input operations
  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_SEL,
    ST_BMUL,
    ST_BNORM,
    ST_BDIV,
    ST_ADV,
    ST_PUSH,
    ST_FINISH
  } state_e;

  // step controls for the blend units
  typedef struct packed {
    logic load_mul;
    logic mul_step;
    logic load_div;
    logic div_step;
  } blend_ctl_t;

endpackage

@@ hdl/slr_blend.sv @@
// one channel of the interpolation: bit-serial weighted sum, then
// bit-serial signed division by the target rate; depends on slr_pkg
module slr_blend (
  input  logic                                    clk_i,
  input  slr_pkg::blend_ctl_t                     ctl_i,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]     prev_i,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]     cur_i,
  input  logic        [slr_pkg::RATE_W-1:0]       weight_prev_i,
  input  logic        [slr_pkg::RATE_W-1:0]       weight_cur_i,
  input  logic        [slr_pkg::RATE_W-1:0]       divisor_i,
  output logic signed [slr_pkg::SAMPLE_W-1:0]     result_o
);

  localparam int unsigned ACC_W = 33;
  localparam int unsigned MAG_W = 32;
  localparam int unsigned RW    = slr_pkg::RATE_W;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic        [RW-1:0]    wp_sh_q, wp_sh_d;
  logic        [RW-1:0]    wc_sh_q, wc_sh_d;
  logic        [MAG_W-1:0] quo_q, quo_d;
  logic        [RW-1:0]    rem_q, rem_d;
  logic                    neg_q, neg_d;

  logic signed [ACC_W-1:0] add_prev, add_cur, acc_abs;
  logic        [RW:0]      trial, trial_sub;
  logic                    fits;

  // shift-add terms, one weight bit of each sample per cycle
  assign add_prev = wp_sh_q[RW-1] ? ACC_W'(prev_i) : '0;
  assign add_cur  = wc_sh_q[RW-1] ? ACC_W'(cur_i) : '0;
  assign acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;

  // restoring division step on the magnitude
  assign trial     = {rem_q, quo_q[MAG_W-1]};
  assign fits      = trial >= {1'b0, divisor_i};
  assign trial_sub = trial - {1'b0, divisor_i};

  always_comb begin
    acc_d   = acc_q;
    wp_sh_d = wp_sh_q;
    wc_sh_d = wc_sh_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    if (ctl_i.load_mul) begin
      acc_d   = '0;
      wp_sh_d = weight_prev_i;
      wc_sh_d = weight_cur_i;
    end else if (ctl_i.mul_step) begin
      acc_d   = (acc_q <<< 1) + add_prev + add_cur;
      wp_sh_d = {wp_sh_q[RW-2:0], 1'b0};
      wc_sh_d = {wc_sh_q[RW-2:0], 1'b0};
    end else if (ctl_i.load_div) begin
      neg_d = acc_q[ACC_W-1];
      quo_d = acc_abs[MAG_W-1:0];
      rem_d = '0;
    end else if (ctl_i.div_step) begin
      rem_d = fits ? trial_sub[RW-1:0] : trial[RW-1:0];
      quo_d = {quo_q[MAG_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    wp_sh_q <= wp_sh_d;
    wc_sh_q <= wc_sh_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
  end

  // quotient magnitude stays within one sample, so truncation toward zero is exact
  assign result_o = neg_q ? -quo_q[slr_pkg::SAMPLE_W-1:0] : quo_q[slr_pkg::SAMPLE_W-1:0];

endmodule

@@ hdl/stereo_linear_resampler_unit.sv @@
// stereo linear resampler, top level; depends on slr_pkg and slr_blend; one frame at a time
// a position search is a serial multiply, a serial division and a check; each output adds
// a search (not the MAX_RATIO-th) and a blend or a pass-through, plus output stalls;
// reset clears counters, history flag, output valid; rates 48000
module stereo_linear_resampler_unit #(
  parameter int unsigned MAX_RATIO  = 6,
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [slr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [slr_pkg::RATE_W-1:0]           cfg_data_i,
  // source frames
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]  in_left_i,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]  in_right_i,
  // resampled frames
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [slr_pkg::SAMPLE_W-1:0]  out_left_o,
  output logic signed [slr_pkg::SAMPLE_W-1:0]  out_right_o,
  output logic                                 last_o
);

  localparam int unsigned RW     = slr_pkg::RATE_W;
  localparam int unsigned SW     = slr_pkg::SAMPLE_W;
  localparam int unsigned PW     = COUNT_BITS + RW;
  localparam int unsigned CNT_W  = $clog2(PW);
  localparam int unsigned NW     = $clog2(MAX_RATIO + 1);
  localparam bit          NEED_WRAPS = (COUNT_BITS >= 64);

  slr_pkg::state_e state_q, state_d;

  logic [RW-1:0]         src_rate_q, tgt_rate_q;
  logic [RW-1:0]         t_eff;
  logic [COUNT_BITS-1:0] in_cnt_q, out_cnt_q;
  logic                  primed_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NW-1:0]         n_q;
  logic                  have_hold_q;
  logic                  out_valid_q;

  logic [PW-1:0]         prod_q;
  logic [RW-1:0]         pos_rem_q;
  logic [RW-1:0]         s_sh_q;
  logic signed [SW-1:0]  cur_l_q, cur_r_q, prev_l_q, prev_r_q;
  logic signed [SW-1:0]  hold_l_q, hold_r_q;
  logic signed [SW-1:0]  out_l_q, out_r_q;
  logic                  out_last_q;
  logic                  blend_q, push_last_q, more_q;

  logic                  in_xfer, out_xfer, out_load, cnt_done;
  logic [RW:0]           trial, trial_sub;
  logic                  fits;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS:0]   need_full;
  logic                  qual, use_blend, last_slot;
  logic [RW-1:0]         weight_prev;
  logic signed [SW-1:0]  blend_l, blend_r;
  slr_pkg::blend_ctl_t   bctl;

  // a zero target rate acts as one
  assign t_eff = (tgt_rate_q == '0) ? RW'(1) : tgt_rate_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign cnt_done = (cnt_q == '0);

  // restoring division step for the output position
  assign trial     = {pos_rem_q, prod_q[PW-1]};
  assign fits      = trial >= {1'b0, t_eff};
  assign trial_sub = trial - {1'b0, t_eff};

  // readiness of the pending output and the choice of interpolation
  assign base      = prod_q[COUNT_BITS-1:0];
  assign need_full = {1'b0, base} + (COUNT_BITS+1)'(pos_rem_q != '0);
  assign qual      = NEED_WRAPS ? (need_full[COUNT_BITS-1:0] <= in_cnt_q)
                                : (need_full <= {1'b0, in_cnt_q});
  assign use_blend = (base != in_cnt_q) && (in_cnt_q != '0);
  assign last_slot = (n_q + NW'(1)) == NW'(MAX_RATIO);
  assign weight_prev = t_eff - pos_rem_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slr_pkg::ST_IDLE: begin
        if (in_xfer && (op_i == slr_pkg::OP_FRAME)) state_d = slr_pkg::ST_MUL;
      end
      slr_pkg::ST_MUL:    if (cnt_done) state_d = slr_pkg::ST_DIV;
      slr_pkg::ST_DIV:    if (cnt_done) state_d = slr_pkg::ST_CHECK;
      slr_pkg::ST_CHECK: begin
        if (have_hold_q) state_d = slr_pkg::ST_PUSH;
        else if (qual)   state_d = slr_pkg::ST_SEL;
        else             state_d = slr_pkg::ST_FINISH;
      end
      slr_pkg::ST_SEL:    state_d = blend_q ? slr_pkg::ST_BMUL : slr_pkg::ST_ADV;
      slr_pkg::ST_BMUL:   if (cnt_done) state_d = slr_pkg::ST_BNORM;
      slr_pkg::ST_BNORM:  state_d = slr_pkg::ST_BDIV;
      slr_pkg::ST_BDIV:   if (cnt_done) state_d = slr_pkg::ST_ADV;
      slr_pkg::ST_ADV:    state_d = last_slot ? slr_pkg::ST_PUSH : slr_pkg::ST_MUL;
      slr_pkg::ST_PUSH: begin
        if (out_load) state_d = more_q ? slr_pkg::ST_SEL : slr_pkg::ST_FINISH;
      end
      slr_pkg::ST_FINISH: state_d = slr_pkg::ST_IDLE;
      default:            state_d = slr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_load      = 1'b0;
    bctl          = '0;
    case (state_q)
      slr_pkg::ST_IDLE:  in_ready_o    = 1'b1;
      slr_pkg::ST_SEL:   bctl.load_mul = blend_q;
      slr_pkg::ST_BMUL:  bctl.mul_step = 1'b1;
      slr_pkg::ST_BNORM: bctl.load_div = 1'b1;
      slr_pkg::ST_BDIV:  bctl.div_step = 1'b1;
      slr_pkg::ST_PUSH:  out_load      = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slr_pkg::ST_IDLE;
      src_rate_q  <= slr_pkg::RATE_RESET;
      tgt_rate_q  <= slr_pkg::RATE_RESET;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      primed_q    <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
      have_hold_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes, unused indexes ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          slr_pkg::REG_SOURCE_RATE: src_rate_q <= cfg_data_i;
          slr_pkg::REG_TARGET_RATE: tgt_rate_q <= cfg_data_i;
          default: ;
        endcase
      end

      // frame transfer or restart
      if (in_xfer) begin
        if (op_i == slr_pkg::OP_RESTART) begin
          in_cnt_q  <= '0;
          out_cnt_q <= '0;
          primed_q  <= 1'b0;
        end else begin
          primed_q    <= 1'b1;
          n_q         <= '0;
          have_hold_q <= 1'b0;
          cnt_q       <= CNT_W'(slr_pkg::MUL_CYC - 1);
        end
      end

      // step counter
      case (state_q)
        slr_pkg::ST_MUL:   cnt_q <= cnt_done ? CNT_W'(PW - 1) : cnt_q - CNT_W'(1);
        slr_pkg::ST_DIV:   cnt_q <= cnt_q - CNT_W'(1);
        slr_pkg::ST_SEL:   cnt_q <= CNT_W'(slr_pkg::MUL_CYC - 1);
        slr_pkg::ST_BMUL:  cnt_q <= cnt_q - CNT_W'(1);
        slr_pkg::ST_BNORM: cnt_q <= CNT_W'(slr_pkg::BDIV_CYC - 1);
        slr_pkg::ST_BDIV:  cnt_q <= cnt_q - CNT_W'(1);
        slr_pkg::ST_ADV:   cnt_q <= CNT_W'(slr_pkg::MUL_CYC - 1);
        default: ;
      endcase

      // one output finished: count it and hold it
      if (state_q == slr_pkg::ST_ADV) begin
        n_q         <= n_q + NW'(1);
        out_cnt_q   <= out_cnt_q + COUNT_BITS'(1);
        have_hold_q <= 1'b1;
      end
      if (out_load) have_hold_q <= 1'b0;

      if (state_q == slr_pkg::ST_FINISH) in_cnt_q <= in_cnt_q + COUNT_BITS'(1);

      // output register
      if (out_load)      out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer && (op_i == slr_pkg::OP_FRAME)) begin
      cur_l_q <= in_left_i;
      cur_r_q <= in_right_i;
      if (!primed_q) begin
        prev_l_q <= in_left_i;
        prev_r_q <= in_right_i;
      end
      prod_q <= '0;
      s_sh_q <= src_rate_q;
    end

    case (state_q)
      // shift-add multiply of the output count by the source rate
      slr_pkg::ST_MUL: begin
        prod_q <= (prod_q << 1) + (s_sh_q[RW-1] ? PW'(out_cnt_q) : '0);
        s_sh_q <= {s_sh_q[RW-2:0], 1'b0};
        if (cnt_done) pos_rem_q <= '0;
      end
      // position quotient shifts in as the dividend shifts out
      slr_pkg::ST_DIV: begin
        pos_rem_q <= fits ? trial_sub[RW-1:0] : trial[RW-1:0];
        prod_q    <= {prod_q[PW-2:0], fits};
      end
      slr_pkg::ST_CHECK: begin
        blend_q     <= use_blend;
        push_last_q <= !qual;
        more_q      <= qual;
      end
      slr_pkg::ST_ADV: begin
        hold_l_q <= blend_q ? blend_l : cur_l_q;
        hold_r_q <= blend_q ? blend_r : cur_r_q;
        if (last_slot) begin
          push_last_q <= 1'b1;
          more_q      <= 1'b0;
        end
        prod_q <= '0;
        s_sh_q <= src_rate_q;
      end
      slr_pkg::ST_FINISH: begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
      end
      default: ;
    endcase

    if (out_load) begin
      out_l_q    <= hold_l_q;
      out_r_q    <= hold_r_q;
      out_last_q <= push_last_q;
    end
  end

  // per-channel interpolation units
  slr_blend u_blend_l (
    .clk_i         (clk_i),
    .ctl_i         (bctl),
    .prev_i        (prev_l_q),
    .cur_i         (cur_l_q),
    .weight_prev_i (weight_prev),
    .weight_cur_i  (pos_rem_q),
    .divisor_i     (t_eff),
    .result_o      (blend_l)
  );

  slr_blend u_blend_r (
    .clk_i         (clk_i),
    .ctl_i         (bctl),
    .prev_i        (prev_r_q),
    .cur_i         (cur_r_q),
    .weight_prev_i (weight_prev),
    .weight_cur_i  (pos_rem_q),
    .divisor_i     (t_eff),
    .result_o      (blend_r)
  );

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign last_o      = out_last_q;

  // no new frame while a computed result is still held back
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_hold_q |-> !in_ready_o)
    else $error("frame accepted while a result is held");

  // per-frame output count never passes the cap
  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_RATIO))
    else $error("too many outputs for one frame");

  // division remainder is below the divisor when the position is checked
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slr_pkg::ST_CHECK) |-> (pos_rem_q < t_eff))
    else $error("position remainder out of range");

  // restart clears the counters and the history flag
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (op_i == slr_pkg::OP_RESTART)) |=>
      (in_cnt_q == '0 && out_cnt_q == '0 && !primed_q))
    else $error("restart did not clear state");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for stereo_linear_resampler_unit
// depends on slr_pkg and the resampler rtl; a built-in predictor checks every output frame
module tb;

  localparam int unsigned SW           = slr_pkg::SAMPLE_W;
  localparam int unsigned RW           = slr_pkg::RATE_W;
  localparam int unsigned IW           = slr_pkg::CFG_IDX_W;
  localparam int unsigned MAX_RATIO    = 6;
  localparam int unsigned COUNT_BITS   = 48;
  localparam logic [63:0] COUNT_MASK   = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT  = 20000;

  // register indexes with no register behind them
  localparam logic [IW-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [IW-1:0] REG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } out_frame_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [IW-1:0]        cfg_idx_i   = '0;
  logic [RW-1:0]        cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 op_i        = slr_pkg::OP_FRAME;
  logic signed [SW-1:0] in_left_i   = '0;
  logic signed [SW-1:0] in_right_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] out_left_o;
  logic signed [SW-1:0] out_right_o;
  logic                 last_o;

  // predictor state and register mirror
  logic [RW-1:0]         src_rate = slr_pkg::RATE_RESET;
  logic [RW-1:0]         tgt_rate = slr_pkg::RATE_RESET;
  logic [COUNT_BITS-1:0] frames_in  = '0;
  logic [COUNT_BITS-1:0] frames_out = '0;
  logic signed [SW-1:0]  hist_left  = '0;
  logic signed [SW-1:0]  hist_right = '0;
  logic                  have_hist  = 1'b0;

  out_frame_t  due_frames[$];
  int unsigned mismatches    = 0;
  int unsigned in_gap_pct    = 33;
  int unsigned out_stall_pct = 33;
  int unsigned quiet_cycles  = 0;

  stereo_linear_resampler_unit #(
    .MAX_RATIO (MAX_RATIO),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .in_left_i  (in_left_i),
    .in_right_i (in_right_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_left_o (out_left_o),
    .out_right_o(out_right_o),
    .last_o     (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // weighted mix of two samples, signed division truncated toward zero
  function automatic logic signed [SW-1:0] mix_samples(
    input logic signed [SW-1:0] older,
    input logic signed [SW-1:0] newer,
    input logic [63:0]          frac,
    input logic [63:0]          denom
  );
    longint num;
    longint quo;
    num = longint'(older) * longint'(denom - frac) + longint'(newer) * longint'(frac);
    quo = num / longint'(denom);
    return quo[SW-1:0];
  endfunction

  // works out the output frames that one accepted input frame causes
  task automatic predict_frame(
    input logic                 op,
    input logic signed [SW-1:0] cur_left,
    input logic signed [SW-1:0] cur_right
  );
    logic [63:0] denom;
    logic [63:0] prod;
    logic [63:0] base;
    logic [63:0] frac;
    logic [63:0] need;
    out_frame_t  made[MAX_RATIO];
    int          n;
    bit          done;
    if (op == slr_pkg::OP_RESTART) begin
      frames_in  = '0;
      frames_out = '0;
      hist_left  = '0;
      hist_right = '0;
      have_hist  = 1'b0;
    end else begin
      denom = (tgt_rate == '0) ? 64'd1 : 64'(tgt_rate);
      if (!have_hist) begin
        hist_left  = cur_left;
        hist_right = cur_right;
        have_hist  = 1'b1;
      end
      n    = 0;
      done = 1'b0;
      while (!done && n < MAX_RATIO) begin
        // position of the next output in source frames
        prod = 64'(frames_out) * 64'(src_rate);
        base = (prod / denom) & COUNT_MASK;
        frac = prod % denom;
        need = base + ((frac != 0) ? 64'd1 : 64'd0);
        if (need > 64'(frames_in)) begin
          done = 1'b1;
        end else begin
          made[n].left  = cur_left;
          made[n].right = cur_right;
          made[n].last  = 1'b0;
          if (base != 64'(frames_in) && frames_in != '0) begin
            made[n].left  = mix_samples(hist_left, cur_left, frac, denom);
            made[n].right = mix_samples(hist_right, cur_right, frac, denom);
          end
          n++;
          frames_out = frames_out + COUNT_BITS'(1);
        end
      end
      for (int k = 0; k < n; k++) begin
        made[k].last = (k == n - 1);
        due_frames.push_back(made[k]);
      end
      hist_left  = cur_left;
      hist_right = cur_right;
      frames_in  = frames_in + COUNT_BITS'(1);
    end
  endtask

  // predict on every input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_frame(op_i, in_left_i, in_right_i);
    end
  end

  // compare every output transfer with the oldest prediction, stall at random
  always @(posedge clk_i) begin : check_outputs
    out_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_frames.size() == 0) begin
        $error("unexpected output frame left=%0d right=%0d last=%0b",
               out_left_o, out_right_o, last_o);
        mismatches++;
      end else begin
        want = due_frames.pop_front();
        if (out_left_o !== want.left) begin
          $error("out_left: expected %0d, got %0d", want.left, out_left_o);
          mismatches++;
        end
        if (out_right_o !== want.right) begin
          $error("out_right: expected %0d, got %0d", want.right, out_right_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatches++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // watchdog on cycles with no transfer and no register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer, with a random gap in front
  task automatic send_frame(
    input logic                 op,
    input logic signed [SW-1:0] left,
    input logic signed [SW-1:0] right
  );
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    in_left_i  <= left;
    in_right_i <= right;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drop valid after the last transfer of a sequence
  task automatic end_input();
    in_valid_i <= 1'b0;
  endtask

  // all predictions seen, then let the block finish its final position search
  task automatic wait_idle();
    @(posedge clk_i);
    while (due_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rates(input logic [RW-1:0] src, input logic [RW-1:0] tgt);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= slr_pkg::REG_SOURCE_RATE;
    cfg_data_i <= src;
    @(posedge clk_i);
    src_rate    = src;
    cfg_idx_i  <= slr_pkg::REG_TARGET_RATE;
    cfg_data_i <= tgt;
    @(posedge clk_i);
    tgt_rate    = tgt;
    cfg_we_i   <= 1'b0;
  endtask

  // write to an index with no register; the block must ignore it
  task automatic poke_unused(input logic [IW-1:0] idx, input logic [RW-1:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // mostly full-range random, sometimes an extreme value
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return SW'($urandom);
    endcase
  endfunction

  // default rates pass samples through; extremes, bit patterns and restarts
  task automatic test_passthrough_extremes();
    send_frame(slr_pkg::OP_RESTART, 16'sh1234, -16'sh1234);
    send_frame(slr_pkg::OP_FRAME, 16'sh8000, 16'sh7FFF);
    send_frame(slr_pkg::OP_FRAME, 16'sh7FFF, 16'sh8000);
    send_frame(slr_pkg::OP_FRAME, 16'sh0000, 16'shFFFF);
    send_frame(slr_pkg::OP_FRAME, 16'sh5555, 16'shAAAA);
    send_frame(slr_pkg::OP_RESTART, 16'sh7FFF, 16'sh7FFF);
    send_frame(slr_pkg::OP_RESTART, 16'sh8000, 16'sh8000);
    send_frame(slr_pkg::OP_FRAME, 16'shAAAA, 16'sh5555);
    end_input();
  endtask

  // up to six outputs per frame, blends between opposite extremes
  task automatic test_upsample_blend();
    set_rates(16'd8000, 16'd48000);
    send_frame(slr_pkg::OP_RESTART, 16'sh0000, 16'sh0000);
    send_frame(slr_pkg::OP_FRAME, 16'sh8000, 16'sh7FFF);
    send_frame(slr_pkg::OP_FRAME, 16'sh7FFF, 16'sh8000);
    send_frame(slr_pkg::OP_FRAME, 16'sh8000, 16'sh7FFF);
    send_frame(slr_pkg::OP_FRAME, -16'sd1, 16'sd1);
    end_input();
  endtask

  // more outputs due than one frame may emit: backlog carries over
  task automatic test_pending_backlog();
    set_rates(16'd8000, 16'hFFFF);
    send_frame(slr_pkg::OP_RESTART, 16'sh0000, 16'sh0000);
    for (int k = 0; k < 4; k++) send_frame(slr_pkg::OP_FRAME, pick_sample(), pick_sample());
    end_input();
  endtask

  // target rate of zero acts as one; source rate of zero puts all outputs at the start
  task automatic test_zero_rates();
    set_rates(16'd2, 16'd0);
    send_frame(slr_pkg::OP_RESTART, 16'sh0000, 16'sh0000);
    for (int k = 0; k < 3; k++) send_frame(slr_pkg::OP_FRAME, pick_sample(), pick_sample());
    end_input();
    set_rates(16'd0, 16'd48000);
    for (int k = 0; k < 3; k++) send_frame(slr_pkg::OP_FRAME, pick_sample(), pick_sample());
    end_input();
    set_rates(16'd0, 16'd0);
    send_frame(slr_pkg::OP_RESTART, 16'sh0000, 16'sh0000);
    for (int k = 0; k < 2; k++) send_frame(slr_pkg::OP_FRAME, pick_sample(), pick_sample());
    end_input();
  endtask

  // writes past the last register leave the rates alone
  task automatic test_unused_index();
    set_rates(16'd44100, 16'd48000);
    poke_unused(REG_UNUSED_A, RW'($urandom));
    poke_unused(REG_UNUSED_B, 16'hFFFF);
    for (int k = 0; k < 3; k++) send_frame(slr_pkg::OP_FRAME, pick_sample(), pick_sample());
    end_input();
  endtask

  // random traffic over several rate settings, one phase with no idling
  task automatic test_random_phases();
    logic [RW-1:0] src;
    logic [RW-1:0] tgt;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin src = 16'd48000; tgt = 16'd8000;  end
        1:       begin src = 16'd8000;  tgt = 16'd8000;  end
        2:       begin src = 16'd44100; tgt = 16'd48000; end
        default: begin
          src = RW'($urandom_range(48000, 8000));
          tgt = RW'($urandom_range(48000, 8000));
        end
      endcase
      in_gap_pct    = (ph == 2) ? 0 : 33;
      out_stall_pct = (ph == 2) ? 0 : 33;
      set_rates(src, tgt);
      for (int k = 0; k < 35; k++) begin
        if ($urandom_range(99) < 4) begin
          send_frame(slr_pkg::OP_RESTART, SW'($urandom), SW'($urandom));
        end else begin
          send_frame(slr_pkg::OP_FRAME, pick_sample(), pick_sample());
        end
      end
      end_input();
    end
    in_gap_pct    = 33;
    out_stall_pct = 33;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough_extremes();
    test_upsample_blend();
    test_pending_backlog();
    test_zero_rates();
    test_unused_index();
    test_random_phases();
    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/slr_pkg.sv
hdl/slr_blend.sv
hdl/stereo_linear_resampler_unit.sv
tb/tb.sv
